>>> rtl/ufsf_pkg.sv
// Shared types, constants and helper functions for the spanning forest cost block.
package ufsf_pkg;

  localparam int NODE_W   = 13;
  localparam int WEIGHT_W = 63;
  localparam int COST_W   = 18;
  localparam int RANK_W   = 4;
  localparam int LG_W     = 6;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [NODE_W-1:0] NUM_NODES_RST = 13'd4096;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // Status of the log2 unit as seen by the sequencer
  typedef struct packed {
    logic            done;
    logic [LG_W-1:0] value;
  } ufsf_lg_t;

  // Position of the highest set bit of a byte (zero for an empty byte)
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        p = 3'(i);
      end
    end
    return p;
  endfunction

endpackage

>>> rtl/ufsf_log2.sv
// Byte-serial floor(log2) unit for the edge weight.
module ufsf_log2 import ufsf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [WEIGHT_W-1:0] weight,
  output ufsf_lg_t            status
);

  logic [63:0]     w_r, w_nxt;
  logic [2:0]      k_r, k_nxt;
  logic            run_r, run_nxt;
  logic            done_r, done_nxt;
  logic [LG_W-1:0] val_r, val_nxt;
  logic [7:0]      chunk;

  assign chunk = w_r[63:56];

  always_comb begin
    w_nxt    = w_r;
    k_nxt    = k_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    val_nxt  = val_r;
    if (start) begin
      w_nxt    = {1'b0, weight};
      k_nxt    = 3'd7;
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      if (chunk != 8'd0 || k_r == 3'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        val_nxt  = {k_r, msb8(chunk)};
      end else begin
        // scan the next byte down
        w_nxt = {w_r[55:0], 8'd0};
        k_nxt = k_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    w_r   <= w_nxt;
    k_r   <= k_nxt;
    val_r <= val_nxt;
  end

  assign status.done  = done_r;
  assign status.value = val_r;

endmodule

>>> rtl/ufsf_table.sv
// Parent and rank table: one write port, one read port with registered read data.
module ufsf_table #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/union_find_spanning_forest_cost.sv
// Top level: union-find sequencer that sums log2 edge weights of merging edges.
//
// Command interface: a transaction is taken when start is high and busy is low; each
// command returns exactly one result, shown for one cycle with out_valid, which the
// receiver must take. After reset the block sweeps the whole parent/rank table, one
// entry a cycle, and busy stays high until the sweep ends. A clear command sweeps the
// first num_nodes entries (at most MAX_NODES) and then reports; with a count of zero
// it reports without a sweep. A rejected edge reports in the next cycle. An accepted
// edge walks both endpoints to their roots through the table's single read port: each
// endpoint is followed one parent hop at a time, and a non-root endpoint's path is
// walked again to point every node at the root (path compression); two different
// roots are then merged, with a rank write when their ranks are equal and below
// RANK_MAX. Union by rank keeps the hop counts near log2 of the set size. The weight's
// log2 is found byte by byte during the walk; a small weight can delay a short edge.
module union_find_spanning_forest_cost import ufsf_pkg::*; #(
  parameter int MAX_NODES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_cmd,
  input  logic [NODE_W-1:0]   in_node_a,
  input  logic [NODE_W-1:0]   in_node_b,
  input  logic [WEIGHT_W-1:0] in_weight,
  output logic                out_valid,
  output logic                out_joined,
  output logic [COST_W-1:0]   out_total_cost,
  output logic                out_error,
  input  logic                cfg_we,
  input  logic [NODE_W-1:0]   cfg_wdata
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = (IW + 1 > NODE_W) ? IW + 1 : NODE_W;
  localparam int EW = IW + RANK_W;
  localparam logic [CW-1:0] MAX_C    = CW'(MAX_NODES);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_NODES - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_FETCH, ST_FIND, ST_CFETCH, ST_COMP, ST_UNION, ST_RANK
  } state_t;

  state_t              state_r, state_nxt;
  logic [NODE_W-1:0]   num_nodes_r, num_nodes_nxt;
  logic [COST_W-1:0]   cost_r, cost_nxt;
  logic [IW-1:0]       cnt_r, cnt_nxt;
  logic [IW-1:0]       last_r, last_nxt;
  logic                rep_r, rep_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;
  logic [IW-1:0]       start_r, start_nxt;
  logic [IW-1:0]       nb_r, nb_nxt;
  logic                side_r, side_nxt;
  logic [IW-1:0]       root_r, root_nxt;
  logic [RANK_W-1:0]   rk_r, rk_nxt;
  logic [IW-1:0]       ra_r, ra_nxt;
  logic [RANK_W-1:0]   rka_r, rka_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_joined_r, out_joined_nxt;
  logic                out_error_r, out_error_nxt;

  logic                we;
  logic [IW-1:0]       waddr, raddr;
  logic [EW-1:0]       wdata, rd_data;
  logic [IW-1:0]       rd_par;
  logic [RANK_W-1:0]   rd_rank;

  logic                lg_start;
  ufsf_lg_t            lg;

  logic [CW-1:0]       num_c, eff_n, a_c, b_c, am1, bm1, eff_m1;
  logic                in_bad;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   cost_sat;
  logic                side_done;
  logic [IW-1:0]       rt_fin;
  logic [RANK_W-1:0]   rk_fin;

  ufsf_table #(.DEPTH(MAX_NODES), .AW(IW), .DW(EW)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  ufsf_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lg_start),
    .weight (in_weight),
    .status (lg)
  );

  assign rd_par  = rd_data[EW-1:RANK_W];
  assign rd_rank = rd_data[RANK_W-1:0];

  assign num_c  = CW'(num_nodes_r);
  assign eff_n  = (num_c > MAX_C) ? MAX_C : num_c;
  assign a_c    = CW'(in_node_a);
  assign b_c    = CW'(in_node_b);
  assign am1    = a_c - CW'(1);
  assign bm1    = b_c - CW'(1);
  assign eff_m1 = eff_n - CW'(1);
  assign in_bad = (a_c == '0) || (b_c == '0) || (a_c > eff_n) || (b_c > eff_n) ||
                  (in_weight == '0);

  assign sum      = {1'b0, cost_r} + (COST_W+1)'(lg.value);
  assign cost_sat = sum[COST_W] ? {COST_W{1'b1}} : sum[COST_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    num_nodes_nxt  = cfg_we ? cfg_wdata : num_nodes_r;
    cost_nxt       = cost_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    rep_nxt        = rep_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    nb_nxt         = nb_r;
    side_nxt       = side_r;
    root_nxt       = root_r;
    rk_nxt         = rk_r;
    ra_nxt         = ra_r;
    rka_nxt        = rka_r;
    out_valid_nxt  = 1'b0;
    out_joined_nxt = out_joined_r;
    out_error_nxt  = out_error_r;
    we             = 1'b0;
    waddr          = cur_r;
    wdata          = '0;
    raddr          = cur_r;
    lg_start       = 1'b0;
    side_done      = 1'b0;
    rt_fin         = root_r;
    rk_fin         = rk_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          lg_start = 1'b1;
          if (in_cmd == CMD_CLEAR) begin
            cost_nxt = '0;
            if (eff_n == '0) begin
              out_valid_nxt  = 1'b1;
              out_joined_nxt = 1'b0;
              out_error_nxt  = 1'b0;
            end else begin
              cnt_nxt   = '0;
              last_nxt  = eff_m1[IW-1:0];
              rep_nxt   = 1'b1;
              state_nxt = ST_CLR;
            end
          end else if (in_bad) begin
            out_valid_nxt  = 1'b1;
            out_joined_nxt = 1'b0;
            out_error_nxt  = 1'b1;
          end else begin
            cur_nxt   = am1[IW-1:0];
            start_nxt = am1[IW-1:0];
            nb_nxt    = bm1[IW-1:0];
            side_nxt  = 1'b0;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_CLR: begin
        we    = 1'b1;
        waddr = cnt_r;
        wdata = {cnt_r, {RANK_W{1'b0}}};
        if (cnt_r == last_r) begin
          state_nxt = ST_IDLE;
          if (rep_r) begin
            out_valid_nxt  = 1'b1;
            out_joined_nxt = 1'b0;
            out_error_nxt  = 1'b0;
          end
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      ST_FETCH: begin
        raddr     = cur_r;
        state_nxt = ST_FIND;
      end
      ST_FIND: begin
        if (rd_par == cur_r) begin
          root_nxt = cur_r;
          rk_nxt   = rd_rank;
          if (cur_r == start_r) begin
            side_done = 1'b1;
            rt_fin    = cur_r;
            rk_fin    = rd_rank;
          end else begin
            // walk the path again and point every node at the root
            cur_nxt   = start_r;
            state_nxt = ST_CFETCH;
          end
        end else begin
          cur_nxt = rd_par;
          raddr   = rd_par;
        end
      end
      ST_CFETCH: begin
        raddr     = cur_r;
        state_nxt = ST_COMP;
      end
      ST_COMP: begin
        we    = 1'b1;
        waddr = cur_r;
        wdata = {root_r, rd_rank};
        if (rd_par == root_r) begin
          side_done = 1'b1;
        end else begin
          cur_nxt = rd_par;
          raddr   = rd_par;
        end
      end
      ST_UNION: begin
        if (lg.done) begin
          if (ra_r == root_r) begin
            out_valid_nxt  = 1'b1;
            out_joined_nxt = 1'b0;
            out_error_nxt  = 1'b0;
            state_nxt      = ST_IDLE;
          end else begin
            cost_nxt = cost_sat;
            we       = 1'b1;
            if (rka_r > rk_r) begin
              waddr          = root_r;
              wdata          = {ra_r, rk_r};
              out_valid_nxt  = 1'b1;
              out_joined_nxt = 1'b1;
              out_error_nxt  = 1'b0;
              state_nxt      = ST_IDLE;
            end else begin
              waddr = ra_r;
              wdata = {root_r, rka_r};
              if (rka_r == rk_r && rk_r != RANK_MAX) begin
                state_nxt = ST_RANK;
              end else begin
                out_valid_nxt  = 1'b1;
                out_joined_nxt = 1'b1;
                out_error_nxt  = 1'b0;
                state_nxt      = ST_IDLE;
              end
            end
          end
        end
      end
      ST_RANK: begin
        we             = 1'b1;
        waddr          = root_r;
        wdata          = {root_r, rk_r + RANK_W'(1)};
        out_valid_nxt  = 1'b1;
        out_joined_nxt = 1'b1;
        out_error_nxt  = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (side_done) begin
      root_nxt = rt_fin;
      rk_nxt   = rk_fin;
      if (!side_r) begin
        ra_nxt    = rt_fin;
        rka_nxt   = rk_fin;
        side_nxt  = 1'b1;
        cur_nxt   = nb_r;
        start_nxt = nb_r;
        state_nxt = ST_FETCH;
      end else begin
        state_nxt = ST_UNION;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      num_nodes_r <= NUM_NODES_RST;
      cost_r      <= '0;
      cnt_r       <= '0;
      last_r      <= LAST_IDX;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      num_nodes_r <= num_nodes_nxt;
      cost_r      <= cost_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    nb_r         <= nb_nxt;
    side_r       <= side_nxt;
    root_r       <= root_nxt;
    rk_r         <= rk_nxt;
    ra_r         <= ra_nxt;
    rka_r        <= rka_nxt;
    out_joined_r <= out_joined_nxt;
    out_error_r  <= out_error_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_joined     = out_joined_r;
  assign out_error      = out_error_r;
  assign out_total_cost = cost_r;

endmodule

>>> rtl/ufsf_chk.sv
// Port-level checker for the spanning forest cost block, bound to the top level.
module ufsf_chk import ufsf_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                in_cmd,
  input logic [WEIGHT_W-1:0] in_weight,
  input logic                out_valid,
  input logic                out_joined,
  input logic                out_error
);

  // table sweep runs after reset
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_join_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_joined && out_error))
    else $error("result both joined and rejected");

  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_EDGE && in_weight == '0) |=> (out_valid && out_error))
    else $error("zero weight edge not rejected in next cycle");

  a_err_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> $past(start && !busy))
    else $error("error result without a transaction just before");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

endmodule

bind union_find_spanning_forest_cost ufsf_chk u_ufsf_chk (.*);

>>> test/ufsf_checker.sv
// Checker for the spanning forest cost block: tracks the disjoint-set state and compares results.
module ufsf_checker import ufsf_pkg::*; #(
  parameter int MAX_NODES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic                in_cmd,
  input  logic [NODE_W-1:0]   in_node_a,
  input  logic [NODE_W-1:0]   in_node_b,
  input  logic [WEIGHT_W-1:0] in_weight,
  input  logic                out_valid,
  input  logic                out_joined,
  input  logic [COST_W-1:0]   out_total_cost,
  input  logic                out_error,
  input  logic                cfg_we,
  input  logic [NODE_W-1:0]   cfg_wdata,
  output int                  pending,
  output int                  mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [COST_W-1:0] COST_CAP = '1;

  typedef struct packed {
    logic              joined;
    logic [COST_W-1:0] total;
    logic              error;
  } forest_result_t;

  logic [IDX_W-1:0]  parent_of [MAX_NODES];
  logic [RANK_W-1:0] rank_of [MAX_NODES];
  logic [COST_W-1:0] cost_acc;
  logic [NODE_W-1:0] node_count;

  forest_result_t expected_results[$];
  forest_result_t oldest;

  initial begin
    pending = 0;
    mismatches = 0;
  end

  function automatic logic [IDX_W-1:0] root_of(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] nx;
    int steps;
    r = v;
    steps = 0;
    while (parent_of[r] != r && steps < MAX_NODES) begin
      r = parent_of[r];
      steps++;
    end
    // point every node on the path straight at the root
    cur = v;
    steps = 0;
    while (cur != r && steps < MAX_NODES) begin
      nx = parent_of[cur];
      parent_of[cur] = r;
      cur = nx;
      steps++;
    end
    return r;
  endfunction

  function automatic logic [5:0] weight_log2(input logic [WEIGHT_W-1:0] w);
    logic [5:0] k;
    k = '0;
    for (int i = 0; i < WEIGHT_W; i++) begin
      if (w[i]) begin
        k = 6'(i);
      end
    end
    return k;
  endfunction

  function automatic forest_result_t predict_command(input logic cmd,
                                                     input logic [NODE_W-1:0] a,
                                                     input logic [NODE_W-1:0] b,
                                                     input logic [WEIGHT_W-1:0] w);
    forest_result_t res;
    int n;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
    logic [COST_W:0] sum;
    res = '0;
    n = (int'(node_count) > MAX_NODES) ? MAX_NODES : int'(node_count);
    if (cmd == CMD_CLEAR) begin
      for (int i = 0; i < n; i++) begin
        parent_of[i] = IDX_W'(i);
        rank_of[i] = '0;
      end
      cost_acc = '0;
    end else if (a == 0 || b == 0 || int'(a) > n || int'(b) > n || w == 0) begin
      res.error = 1'b1;
    end else begin
      ra = root_of(IDX_W'(a - 1));
      rb = root_of(IDX_W'(b - 1));
      if (ra != rb) begin
        sum = {1'b0, cost_acc} + (COST_W+1)'(weight_log2(w));
        cost_acc = (sum > COST_CAP) ? COST_CAP : sum[COST_W-1:0];
        if (rank_of[ra] > rank_of[rb]) begin
          parent_of[rb] = ra;
        end else begin
          parent_of[ra] = rb;
          if (rank_of[ra] == rank_of[rb] && rank_of[rb] < RANK_MAX) begin
            rank_of[rb] = rank_of[rb] + RANK_W'(1);
          end
        end
        res.joined = 1'b1;
      end
    end
    res.total = cost_acc;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        parent_of[i] = IDX_W'(i);
        rank_of[i] = '0;
      end
      cost_acc = '0;
      node_count = NUM_NODES_RST;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        node_count = cfg_wdata;
      end
      // retire the finished transaction before taking a new one in the same cycle
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result: joined %0d total %0d error %0d", $realtime,
                     out_joined, out_total_cost, out_error);
          end
        end else begin
          oldest = expected_results.pop_front();
          if (out_joined !== oldest.joined || out_total_cost !== oldest.total ||
              out_error !== oldest.error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch (expected/actual): joined %0d/%0d total %0d/%0d error %0d/%0d",
                       $realtime, oldest.joined, out_joined, oldest.total, out_total_cost,
                       oldest.error, out_error);
            end
          end
        end
      end
      if (start && !busy) begin
        expected_results.insert(expected_results.size(),
                                predict_command(in_cmd, in_node_a, in_node_b, in_weight));
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> test/tb_union_find_spanning_forest_cost.sv
// Testbench top for the spanning forest cost block: drives commands and reports the verdict.
module tb_union_find_spanning_forest_cost;
  import ufsf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES = 4096;
  localparam int ITEM_TARGET = 1650;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_cmd;
  logic [NODE_W-1:0]   in_node_a;
  logic [NODE_W-1:0]   in_node_b;
  logic [WEIGHT_W-1:0] in_weight;
  logic                out_valid;
  logic                out_joined;
  logic [COST_W-1:0]   out_total_cost;
  logic                out_error;
  logic                cfg_we;
  logic [NODE_W-1:0]   cfg_wdata;
  int                  pending;
  int                  mismatches;
  int                  active_nodes;
  int                  sent;

  union_find_spanning_forest_cost #(.MAX_NODES(MAX_NODES)) dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_node_a, .in_node_b, .in_weight,
    .out_valid, .out_joined, .out_total_cost, .out_error, .cfg_we, .cfg_wdata
  );

  ufsf_checker #(.MAX_NODES(MAX_NODES)) u_checker (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_node_a, .in_node_b, .in_weight,
    .out_valid, .out_joined, .out_total_cost, .out_error, .cfg_we, .cfg_wdata,
    .pending, .mismatches
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic send_command(input logic cmd, input logic [NODE_W-1:0] a,
                              input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w,
                              input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_node_a <= a;
    in_node_b <= b;
    in_weight <= w;
    // hold until the block takes the transaction
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic set_node_count(input logic [NODE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    active_nodes = (int'(v) > MAX_NODES) ? MAX_NODES : int'(v);
  endtask

  function automatic logic [WEIGHT_W-1:0] random_weight();
    return WEIGHT_W'({$urandom, $urandom});
  endfunction

  function automatic int gap_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  initial begin
    int sel;
    int edges;
    int exp_cur;
    bit quiet;
    bit sorted;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic [WEIGHT_W-1:0] w;

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_CLEAR;
    in_node_a = '0;
    in_node_b = '0;
    in_weight = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    active_nodes = MAX_NODES;
    sent = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset node count, range limits, weights at their extremes
    send_command(CMD_EDGE, 13'd1, 13'd4096, WEIGHT_W'(1), gap_draw(0));
    send_command(CMD_EDGE, 13'd4096, 13'd1, WEIGHT_W'(1) << 62, gap_draw(0));
    send_command(CMD_EDGE, 13'd2, 13'd2, WEIGHT_W'(8), gap_draw(0));
    send_command(CMD_EDGE, 13'd0, 13'd3, WEIGHT_W'(4), gap_draw(0));
    send_command(CMD_EDGE, 13'd3, 13'd0, WEIGHT_W'(4), gap_draw(0));
    send_command(CMD_EDGE, 13'd4097, 13'd3, WEIGHT_W'(4), gap_draw(0));
    send_command(CMD_EDGE, 13'd3, 13'd8191, WEIGHT_W'(4), gap_draw(0));
    send_command(CMD_EDGE, 13'd2, 13'd3, '0, gap_draw(0));
    send_command(CMD_EDGE, 13'd2, 13'd3, '1, gap_draw(0));
    send_command(CMD_EDGE, 13'd5, 13'd6, WEIGHT_W'(1) << 62, gap_draw(0));
    send_command(CMD_EDGE, 13'd7, 13'd8, WEIGHT_W'(3), gap_draw(0));
    send_command(CMD_EDGE, 13'd7, 13'd9, WEIGHT_W'(63'h2aaa_5555_0f0f_f0f0), gap_draw(0));
    send_command(CMD_EDGE, 13'd3, 13'd6, WEIGHT_W'(1) << 10, gap_draw(0));
    send_command(CMD_EDGE, 13'd2, 13'd5, WEIGHT_W'(2), gap_draw(0));
    send_command(CMD_CLEAR, '1, '1, '1, gap_draw(0));
    send_command(CMD_EDGE, 13'd1, 13'd4096, WEIGHT_W'(2), gap_draw(0));
    drain_results();
    set_node_count('0);
    send_command(CMD_CLEAR, '0, '0, '0, gap_draw(0));
    send_command(CMD_EDGE, 13'd1, 13'd1, WEIGHT_W'(1), gap_draw(0));
    drain_results();
    set_node_count('1);
    send_command(CMD_EDGE, 13'd4096, 13'd4095, WEIGHT_W'(2), gap_draw(0));
    send_command(CMD_EDGE, 13'd4097, 13'd1, WEIGHT_W'(2), gap_draw(0));
    drain_results();
    set_node_count(13'd1);
    send_command(CMD_CLEAR, '0, '0, '0, gap_draw(0));
    send_command(CMD_EDGE, 13'd1, 13'd1, WEIGHT_W'(1), gap_draw(0));
    send_command(CMD_EDGE, 13'd1, 13'd2, WEIGHT_W'(1), gap_draw(0));

    // random phases: one node count each, mostly well-formed edge streams
    while (sent < ITEM_TARGET) begin
      drain_results();
      sel = $urandom_range(0, 99);
      if (sel < 55) set_node_count(NODE_W'($urandom_range(1, 32)));
      else if (sel < 75) set_node_count(NODE_W'($urandom_range(33, 300)));
      else if (sel < 82) set_node_count(NODE_W'($urandom_range(301, 4095)));
      else if (sel < 88) set_node_count(NODE_W'(4096));
      else if (sel < 93) set_node_count(NODE_W'($urandom_range(4097, 8191)));
      else if (sel < 96) set_node_count('0);
      else set_node_count(NODE_W'($urandom_range(1, 2)));
      quiet = ($urandom_range(0, 3) == 0);
      sorted = $urandom_range(0, 1);
      exp_cur = 0;
      if ($urandom_range(0, 9) != 0) begin
        send_command(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom), random_weight(),
                     gap_draw(quiet));
      end
      edges = $urandom_range(5, 60);
      repeat (edges) begin
        sel = $urandom_range(0, 99);
        if (active_nodes > 0) begin
          a = NODE_W'($urandom_range(1, active_nodes));
          b = NODE_W'($urandom_range(1, active_nodes));
        end else begin
          a = NODE_W'($urandom);
          b = NODE_W'($urandom);
        end
        if (sorted) begin
          exp_cur = (exp_cur + $urandom_range(0, 1) > 62) ? 62 : exp_cur + $urandom_range(0, 1);
          w = WEIGHT_W'(1) << exp_cur;
        end else begin
          w = WEIGHT_W'(1) << $urandom_range(0, 62);
        end
        if (sel < 80) begin
          send_command(CMD_EDGE, a, b, w, gap_draw(quiet));
        end else if (sel < 86) begin
          send_command(CMD_EDGE, NODE_W'($urandom), NODE_W'($urandom), random_weight(),
                       gap_draw(quiet));
        end else if (sel < 90) begin
          send_command(CMD_EDGE, a, b, '0, gap_draw(quiet));
        end else if (sel < 96) begin
          send_command(CMD_EDGE, a, b, random_weight(), gap_draw(quiet));
        end else if (sel < 98) begin
          send_command(CMD_EDGE, a, a, w, gap_draw(quiet));
        end else begin
          send_command(CMD_CLEAR, a, b, w, gap_draw(quiet));
        end
        // now and then let everything drain mid-phase
        if ($urandom_range(0, 49) == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (32) @(negedge clk);
    if (mismatches == 0) begin
      $display("union_find_spanning_forest_cost test passed");
    end else begin
      $display("union_find_spanning_forest_cost test failed");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("union_find_spanning_forest_cost test failed");
    $finish;
  end

endmodule
